### rtl/vat_pkg.sv
// vat_pkg: shared types, constants and the arctangent table of the vertex transform
// no dependencies; imported by every module of the block
`default_nettype none

package vat_pkg;

    // parameter defaults
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int COORD_WIDTH_DEF  = 32;

    // cordic sizing: table length, iteration index, working widths
    localparam int ATAN_LEN = 30;
    localparam int ITER_W   = $clog2(ATAN_LEN);
    localparam int CX_W     = 52;
    localparam int Z_W      = 34;
    localparam int MUL_W    = 33;
    localparam int ACC_W    = 34;
    localparam int FIN_W    = 50;

    // constants of the transform
    localparam logic [31:0] GAIN_Q32  = 32'd2608131496;
    localparam logic [31:0] SCALE_ONE = 32'h0001_0000;

    // configuration port
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X = 3'd0,
        CFG_OFFSET_Y = 3'd1,
        CFG_PIVOT_X  = 3'd2,
        CFG_PIVOT_Y  = 3'd3,
        CFG_SCALE_X  = 3'd4,
        CFG_SCALE_Y  = 3'd5,
        CFG_ANGLE    = 3'd6
    } t_cfg_idx;

    // transform modes of an item
    typedef enum logic [1:0] {
        MODE_TRANSLATE = 2'd0,
        MODE_MOVE_TO   = 2'd1,
        MODE_SCALE     = 2'd2,
        MODE_ROTATE    = 2'd3
    } t_mode;

    // multiplier operand selection
    typedef enum logic [1:0] {
        MUL_SCALE   = 2'd0,
        MUL_GAIN_LO = 2'd1,
        MUL_GAIN_HI = 2'd2
    } t_mul_sel;

    // configuration register bank
    typedef struct packed {
        logic [31:0] offset_x;
        logic [31:0] offset_y;
        logic [31:0] pivot_x;
        logic [31:0] pivot_y;
        logic [31:0] scale_x;
        logic [31:0] scale_y;
        logic [15:0] angle;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic              load;
        logic              step;
        logic [ITER_W-1:0] iter;
        logic              mul_en;
        t_mul_sel          mul_sel;
        logic              acc_lo;
        logic              round;
        logic              finish;
    } t_dp_cmd;

    // arctangent of 2^-i as a 32-bit fraction of a full turn
    function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd41;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            5'd28:   v = 32'd3;
            5'd29:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/vertex_affine_transform_top.sv
// vertex_affine_transform_top: top level of the 2d vertex transform
// depends on vat_pkg, vat_cfg_regs, vat_ctrl, vat_datapath
`default_nettype none

// Transforms one signed Q16.16 vertex per item by translate, move-to, scale about the
// pivot or rotate about the pivot, saturating both coordinates and flagging clipping.
// An item is taken only while the sequencer is idle; its result then sits in an output
// register so the next item can be taken while the result waits. Scale uses one
// registered multiply per axis. Rotate runs min(CORDIC_STEPS,30) iterations of the
// shift-add cordic loop, one iteration per cycle, followed by a gain multiply in two
// 32-bit halves and a rounding add. Configuration writes are always accepted and
// must be issued only while no item is in flight.
module vertex_affine_transform_top
    import vat_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [1:0]           i_mode,
    input  wire logic [31:0]          i_vertex_x,
    input  wire logic [31:0]          i_vertex_y,
    input  wire logic                 i_group_first,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [31:0]               o_out_x,
    output logic [31:0]               o_out_y,
    output logic                      o_saturated
);

    t_cfg    cfg;
    t_dp_cmd cmd;

    // configuration registers
    vat_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    // sequencer
    vat_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // arithmetic and output register
    vat_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (cfg),
        .i_mode        (i_mode),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_group_first (i_group_first),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_saturated   (o_saturated)
    );

endmodule

`default_nettype wire

### rtl/vat_cfg_regs.sv
// vat_cfg_regs: configuration register bank of the vertex transform
// depends on vat_pkg
`default_nettype none

module vat_cfg_regs
    import vat_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    output logic                      o_cfg_ready,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    // writes are taken at any time
    assign o_cfg_ready = 1'b1;
    assign wr_en       = i_cfg_valid && o_cfg_ready;

    // register bank, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_x <= '0;
            r_cfg.offset_y <= '0;
            r_cfg.pivot_x  <= '0;
            r_cfg.pivot_y  <= '0;
            r_cfg.scale_x  <= SCALE_ONE;
            r_cfg.scale_y  <= SCALE_ONE;
            r_cfg.angle    <= '0;
        end else if (wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_OFFSET_X: r_cfg.offset_x <= i_cfg_data;
                CFG_OFFSET_Y: r_cfg.offset_y <= i_cfg_data;
                CFG_PIVOT_X:  r_cfg.pivot_x  <= i_cfg_data;
                CFG_PIVOT_Y:  r_cfg.pivot_y  <= i_cfg_data;
                CFG_SCALE_X:  r_cfg.scale_x  <= i_cfg_data;
                CFG_SCALE_Y:  r_cfg.scale_y  <= i_cfg_data;
                CFG_ANGLE:    r_cfg.angle    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/vat_ctrl.sv
// vat_ctrl: sequencing state machine of the vertex transform
// depends on vat_pkg; drives vat_datapath through t_dp_cmd
`default_nettype none

module vat_ctrl
    import vat_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_mode,
    input  wire logic       i_out_ready,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output t_dp_cmd         o_cmd
);

    localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(NSTEP - 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b000_0001,
        S_CORDIC   = 7'b000_0010,
        S_MUL      = 7'b000_0100,
        S_GAIN_LO  = 7'b000_1000,
        S_GAIN_HI  = 7'b001_0000,
        S_GAIN_ADD = 7'b010_0000,
        S_FINISH   = 7'b100_0000
    } t_state;

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic              r_out_valid, n_out_valid;
    t_dp_cmd           cmd;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_iter      = r_iter;
        n_out_valid = r_out_valid;
        cmd         = '0;
        cmd.mul_sel = MUL_SCALE;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_iter   = '0;
                    unique case (t_mode'(i_mode))
                        MODE_TRANSLATE: n_state = S_FINISH;
                        MODE_MOVE_TO:   n_state = S_FINISH;
                        MODE_SCALE:     n_state = S_MUL;
                        MODE_ROTATE:    n_state = S_CORDIC;
                    endcase
                end
            end
            S_CORDIC: begin
                cmd.step = 1'b1;
                cmd.iter = r_iter;
                if (r_iter == LAST_ITER) begin
                    n_state = S_GAIN_LO;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            S_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SCALE;
                n_state     = S_FINISH;
            end
            S_GAIN_LO: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAIN_LO;
                n_state     = S_GAIN_HI;
            end
            S_GAIN_HI: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAIN_HI;
                cmd.acc_lo  = 1'b1;
                n_state     = S_GAIN_ADD;
            end
            S_GAIN_ADD: begin
                cmd.round = 1'b1;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                // result moves to the output register once it is free
                if (!r_out_valid || i_out_ready) begin
                    cmd.finish  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

`ifndef SYNTHESIS
    a_finish_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result written over an unread output");

    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORDIC) |-> (r_iter <= LAST_ITER))
        else $error("cordic iteration index out of range");

    a_rotate_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && i_mode == MODE_ROTATE) |=> (r_state == S_CORDIC && r_iter == '0))
        else $error("rotation did not start at the first iteration");

    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_out_valid) |-> $past(i_out_ready))
        else $error("output item dropped without a handshake");
`endif

endmodule

`default_nettype wire

### rtl/vat_datapath.sv
// vat_datapath: cordic unit, shared multipliers, move-to offsets and output register
// depends on vat_pkg; commanded by vat_ctrl
`default_nettype none

module vat_datapath
    import vat_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    input  wire t_cfg        i_cfg,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_vertex_x,
    input  wire logic [31:0] i_vertex_y,
    input  wire logic        i_group_first,
    output logic [31:0]      o_out_x,
    output logic [31:0]      o_out_y,
    output logic             o_saturated
);

    localparam int SAT_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam logic signed [FIN_W-1:0] SAT_HI = (FIN_W'(1) <<< (SAT_W - 1)) - FIN_W'(1);
    localparam logic signed [FIN_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(32768);

    // lane 0 is x, lane 1 is y
    logic signed [31:0]       in_vtx [2];
    logic signed [31:0]       off    [2];
    logic signed [31:0]       piv    [2];
    logic signed [31:0]       scl    [2];
    logic signed [32:0]       vtx_ext[2];
    logic signed [32:0]       piv_ext[2];
    logic signed [32:0]       off_ext[2];
    logic signed [32:0]       d_load [2];
    logic signed [CX_W-1:0]   c_sh   [2];
    logic signed [CX_W-1:0]   c_next [2];
    logic signed [MUL_W-1:0]  mul_a  [2];
    logic signed [MUL_W-1:0]  mul_b  [2];
    logic signed [2*MUL_W-1:0] prod  [2];
    logic                     trunc_fix[2];
    logic signed [53:0]       rsum   [2];
    logic signed [FIN_W-1:0]  fin_a  [2];
    logic signed [FIN_W-1:0]  fin_b  [2];
    logic signed [FIN_W-1:0]  fin_sum[2];
    logic signed [FIN_W-1:0]  clip_v [2];
    logic                     sat    [2];

    t_mode                    in_mode;
    logic                     rot_neg;
    logic [15:0]              theta;
    logic signed [Z_W-1:0]    z_init;
    logic signed [Z_W-1:0]    atan_ext;
    logic                     z_pos;

    t_mode                     r_mode;
    logic signed [Z_W-1:0]     r_z;
    logic signed [31:0]        r_vtx [2];
    logic signed [32:0]        r_d   [2];
    logic signed [CX_W-1:0]    r_c   [2];
    logic signed [2*MUL_W-1:0] r_prod[2];
    logic [ACC_W-1:0]          r_acc [2];
    logic signed [37:0]        r_rot [2];
    logic signed [32:0]        r_move[2];
    logic [31:0]               r_out [2];
    logic                      r_sat;

    // operand fan-in per lane
    always_comb begin
        in_vtx[0] = i_vertex_x;
        in_vtx[1] = i_vertex_y;
        off[0]    = i_cfg.offset_x;
        off[1]    = i_cfg.offset_y;
        piv[0]    = i_cfg.pivot_x;
        piv[1]    = i_cfg.pivot_y;
        scl[0]    = i_cfg.scale_x;
        scl[1]    = i_cfg.scale_y;
    end

    // load: offsets from pivot, quadrant fold for angles in the second and third quadrants
    assign in_mode  = t_mode'(i_mode);
    assign rot_neg  = (in_mode == MODE_ROTATE) && (i_cfg.angle[15] ^ i_cfg.angle[14]);
    assign theta    = rot_neg ? {~i_cfg.angle[15], i_cfg.angle[14:0]} : i_cfg.angle;
    assign z_init   = {{(Z_W - 32){theta[15]}}, theta, 16'b0};

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            vtx_ext[k] = {in_vtx[k][31], in_vtx[k]};
            piv_ext[k] = {piv[k][31], piv[k]};
            off_ext[k] = {off[k][31], off[k]};
            d_load[k]  = rot_neg ? (piv_ext[k] - vtx_ext[k]) : (vtx_ext[k] - piv_ext[k]);
        end
    end

    // one cordic micro-rotation, floor shifts
    assign z_pos    = !r_z[Z_W-1];
    assign atan_ext = {{(Z_W - 32){1'b0}}, atan_turn(i_cmd.iter)};

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            c_sh[k] = r_c[k] >>> i_cmd.iter;
        end
        c_next[0] = z_pos ? (r_c[0] - c_sh[1]) : (r_c[0] + c_sh[1]);
        c_next[1] = z_pos ? (r_c[1] + c_sh[0]) : (r_c[1] - c_sh[0]);
    end

    // shared multiplier per lane: scale factor or the two halves of the gain product
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            unique case (i_cmd.mul_sel)
                MUL_SCALE: begin
                    mul_a[k] = r_d[k];
                    mul_b[k] = {scl[k][31], scl[k]};
                end
                MUL_GAIN_LO: begin
                    mul_a[k] = {1'b0, r_c[k][31:0]};
                    mul_b[k] = {1'b0, GAIN_Q32};
                end
                MUL_GAIN_HI: begin
                    mul_a[k] = {{(MUL_W - (CX_W - 32)){r_c[k][CX_W-1]}}, r_c[k][CX_W-1:32]};
                    mul_b[k] = {1'b0, GAIN_Q32};
                end
                default: begin
                    mul_a[k] = '0;
                    mul_b[k] = '0;
                end
            endcase
            prod[k] = mul_a[k] * mul_b[k];
            // truncation toward zero needs a carry when a negative product has a remainder
            trunc_fix[k] = r_c[k][CX_W-1] && (r_prod[k][31:0] != 32'd0);
            rsum[k] = {r_prod[k][52], r_prod[k][52:0]} + {20'b0, r_acc[k]};
        end
    end

    // final add and saturation
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            unique case (r_mode)
                MODE_TRANSLATE: begin
                    fin_a[k] = FIN_W'(r_vtx[k]);
                    fin_b[k] = FIN_W'(off[k]);
                end
                MODE_MOVE_TO: begin
                    fin_a[k] = FIN_W'(r_vtx[k]);
                    fin_b[k] = FIN_W'(r_move[k]);
                end
                MODE_SCALE: begin
                    fin_a[k] = FIN_W'(piv[k]);
                    fin_b[k] = FIN_W'($signed(r_prod[k][64:16]));
                end
                MODE_ROTATE: begin
                    fin_a[k] = FIN_W'(piv[k]);
                    fin_b[k] = FIN_W'(r_rot[k]);
                end
            endcase
            fin_sum[k] = fin_a[k] + fin_b[k];
            if (fin_sum[k] > SAT_HI) begin
                clip_v[k] = SAT_HI;
                sat[k]    = 1'b1;
            end else if (fin_sum[k] < SAT_LO) begin
                clip_v[k] = SAT_LO;
                sat[k]    = 1'b1;
            end else begin
                clip_v[k] = fin_sum[k];
                sat[k]    = 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= in_mode;
            r_z    <= z_init;
            for (int k = 0; k < 2; k++) begin
                r_vtx[k] <= in_vtx[k];
                r_d[k]   <= d_load[k];
                r_c[k]   <= {{(CX_W - 49){d_load[k][32]}}, d_load[k], 16'b0};
            end
        end
        if (i_cmd.step) begin
            r_z <= z_pos ? (r_z - atan_ext) : (r_z + atan_ext);
            for (int k = 0; k < 2; k++) begin
                r_c[k] <= c_next[k];
            end
        end
        for (int k = 0; k < 2; k++) begin
            if (i_cmd.mul_en) begin
                r_prod[k] <= prod[k];
            end
            if (i_cmd.acc_lo) begin
                r_acc[k] <= {2'b0, r_prod[k][63:32]} + ROUND_BIAS
                          + {{(ACC_W - 1){1'b0}}, trunc_fix[k]};
            end
            if (i_cmd.round) begin
                r_rot[k] <= rsum[k][53:16];
            end
            if (i_cmd.finish) begin
                r_out[k] <= clip_v[k][31:0];
            end
        end
        if (i_cmd.finish) begin
            r_sat <= sat[0] | sat[1];
        end
    end

    // move-to offsets, latched on the first vertex of a group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move[0] <= '0;
            r_move[1] <= '0;
        end else if (i_cmd.load && in_mode == MODE_MOVE_TO && i_group_first) begin
            for (int k = 0; k < 2; k++) begin
                r_move[k] <= off_ext[k] - vtx_ext[k];
            end
        end
    end

    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_saturated = r_sat;

endmodule

`default_nettype wire

### tb/sv/tb_vertex_affine_transform_top.sv
// tb_vertex_affine_transform_top: self-checking bench for the 2d vertex transform
// needs vat_pkg and vertex_affine_transform_top; a local predictor checks every result
`timescale 1ns / 1ps

module tb_vertex_affine_transform_top
    import vat_pkg::*;
();

    // bench constants
    localparam int     CLK_HALF     = 4;
    localparam int     RESET_CYCLES = 5;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     TIMEOUT_NS   = 5_000_000;
    localparam int     SEG_ITEMS    = 64;
    localparam int     N_SEGMENTS   = 8;
    localparam int     STEPS        = CORDIC_STEPS_DEF;
    localparam int     SAT_W        = (COORD_WIDTH_DEF < 32) ? COORD_WIDTH_DEF : 32;
    localparam longint SAT_HI       = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
    localparam longint SAT_LO       = -SAT_HI - 64'sd1;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_NEG1 = 32'hFFFF_FFFF;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    // turn fraction of atan(2^-i), entry 0 in the low word
    localparam logic [ATAN_LEN*32-1:0] ATAN_WORDS = {
        32'd1, 32'd3, 32'd5, 32'd10, 32'd20, 32'd41, 32'd81, 32'd163, 32'd326, 32'd652,
        32'd1304, 32'd2608, 32'd5215, 32'd10430, 32'd20861, 32'd41722, 32'd83443,
        32'd166886, 32'd333772, 32'd667544, 32'd1335087, 32'd2670163, 32'd5340245,
        32'd10679838, 32'd21354465, 32'd42667331, 32'd85004756, 32'd167458907,
        32'd316933406, 32'd536870912
    };

    typedef struct packed {
        t_mode       mode;
        logic [31:0] vx;
        logic [31:0] vy;
        logic        first;
    } t_vertex_item;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        sat;
    } t_point_result;

    // clock, reset and block ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [1:0]           i_mode = MODE_TRANSLATE;
    logic [31:0]          i_vertex_x = '0;
    logic [31:0]          i_vertex_y = '0;
    logic                 i_group_first = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [31:0]          o_out_x;
    logic [31:0]          o_out_y;
    logic                 o_saturated;

    // predictor copy of registers and move-to state
    longint      cfg_offset_x = 0;
    longint      cfg_offset_y = 0;
    longint      cfg_pivot_x = 0;
    longint      cfg_pivot_y = 0;
    longint      cfg_scale_x = 65536;
    longint      cfg_scale_y = 65536;
    logic [15:0] cfg_angle = '0;
    longint      move_dx = 0;
    longint      move_dy = 0;

    t_vertex_item  vertex_queue[$];
    t_point_result predicted_points[$];
    t_vertex_item  next_vertex;
    t_point_result got_point;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            n_errors = 0;

    vertex_affine_transform_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_group_first (i_group_first),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_saturated   (o_saturated)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // clip to the coordinate range and note any clipping
    function automatic longint clamp_coord(input longint v, inout logic flag);
        if (v > SAT_HI) begin
            flag = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO) begin
            flag = 1'b1;
            return SAT_LO;
        end
        return v;
    endfunction

    // cordic gain on the magnitude, then round half up off the guard bits
    function automatic longint gain_round(input longint v);
        longint unsigned m;
        longint unsigned p;
        longint unsigned g;
        longint          r;
        g = GAIN_Q32;
        m = (v < 0) ? -v : v;
        p = (m >> 32) * g + (((m & 64'hFFFF_FFFF) * g) >> 32);
        r = $signed(p);
        if (v < 0)
            r = -r;
        return (r + 64'sd32768) >>> 16;
    endfunction

    // rotate an offset from the pivot by the configured binary angle
    function automatic void rotate_offset(input longint dx, input longint dy,
                                          output longint rx, output longint ry);
        logic [31:0] theta;
        longint      x;
        longint      y;
        longint      z;
        longint      xs;
        longint      ys;
        longint      at;
        int          i;
        theta = {cfg_angle, 16'h0000};
        x = dx * 64'sd65536;
        y = dy * 64'sd65536;
        // second and third quadrants: flip the vector and take off a half turn
        if (theta >= 32'h4000_0000 && theta < 32'hC000_0000) begin
            x = -x;
            y = -y;
            theta = theta - 32'h8000_0000;
        end
        z = longint'($signed(theta));
        for (i = 0; i < STEPS && i < ATAN_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            at = longint'(ATAN_WORDS[i*32 +: 32]);
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - at;
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + at;
            end
        end
        rx = gain_round(x);
        ry = gain_round(y);
    endfunction

    // expected result of one vertex; updates the move-to difference
    function automatic t_point_result transform_vertex(input t_vertex_item it);
        longint        vx;
        longint        vy;
        longint        rx;
        longint        ry;
        longint        ox;
        longint        oy;
        logic          flag;
        t_point_result r;
        vx = longint'($signed(it.vx));
        vy = longint'($signed(it.vy));
        flag = 1'b0;
        case (it.mode)
            MODE_TRANSLATE: begin
                rx = vx + cfg_offset_x;
                ry = vy + cfg_offset_y;
            end
            MODE_MOVE_TO: begin
                if (it.first) begin
                    move_dx = cfg_offset_x - vx;
                    move_dy = cfg_offset_y - vy;
                end
                rx = vx + move_dx;
                ry = vy + move_dy;
            end
            MODE_SCALE: begin
                rx = cfg_pivot_x + (((vx - cfg_pivot_x) * cfg_scale_x) >>> 16);
                ry = cfg_pivot_y + (((vy - cfg_pivot_y) * cfg_scale_y) >>> 16);
            end
            default: begin
                rotate_offset(vx - cfg_pivot_x, vy - cfg_pivot_y, ox, oy);
                rx = cfg_pivot_x + ox;
                ry = cfg_pivot_y + oy;
            end
        endcase
        rx = clamp_coord(rx, flag);
        ry = clamp_coord(ry, flag);
        r.x = rx[31:0];
        r.y = ry[31:0];
        r.sat = flag;
        return r;
    endfunction

    // input driver: predicts on acceptance, presents the next queued item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                predicted_points.push_back(transform_vertex(
                    {t_mode'(i_mode), i_vertex_x, i_vertex_y, i_group_first}));
            if (!i_in_valid || o_in_ready) begin
                if (vertex_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_vertex = vertex_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_mode <= next_vertex.mode;
                    i_vertex_x <= next_vertex.vx;
                    i_vertex_y <= next_vertex.vy;
                    i_group_first <= next_vertex.first;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compares each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (predicted_points.size() == 0) begin
                    $error("result with no item pending: x %h y %h sat %b",
                           o_out_x, o_out_y, o_saturated);
                    n_errors++;
                end else begin
                    got_point = predicted_points.pop_front();
                    if (o_out_x !== got_point.x) begin
                        $error("out_x mismatch: expected %h, actual %h", got_point.x, o_out_x);
                        n_errors++;
                    end
                    if (o_out_y !== got_point.y) begin
                        $error("out_y mismatch: expected %h, actual %h", got_point.y, o_out_y);
                        n_errors++;
                    end
                    if (o_saturated !== got_point.sat) begin
                        $error("saturated mismatch: expected %b, actual %b",
                               got_point.sat, o_saturated);
                        n_errors++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one register write; the valid is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_OFFSET_X: cfg_offset_x = longint'($signed(data));
            CFG_OFFSET_Y: cfg_offset_y = longint'($signed(data));
            CFG_PIVOT_X:  cfg_pivot_x = longint'($signed(data));
            CFG_PIVOT_Y:  cfg_pivot_y = longint'($signed(data));
            CFG_SCALE_X:  cfg_scale_x = longint'($signed(data));
            CFG_SCALE_Y:  cfg_scale_y = longint'($signed(data));
            CFG_ANGLE:    cfg_angle = data[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] ox, input logic [31:0] oy,
                              input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] sx, input logic [31:0] sy,
                              input logic [15:0] ang);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_PIVOT_X, px);
        write_reg(CFG_PIVOT_Y, py);
        write_reg(CFG_SCALE_X, sx);
        write_reg(CFG_SCALE_Y, sy);
        write_reg(CFG_ANGLE, {16'h0000, ang});
        i_cfg_valid <= 1'b0;
    endtask

    // wait until every item is taken and every result seen, then let the block settle
    task automatic wait_drain();
        @(posedge i_clk);
        while (vertex_queue.size() != 0 || i_in_valid || predicted_points.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_vertex(input t_mode m, input logic [31:0] x, input logic [31:0] y,
                              input logic first);
        vertex_queue.push_back({m, x, y, first});
    endtask

    // coordinates: extremes, small values near the origin, full range
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(15))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'h0000_0000;
            3: return Q_NEG1;
            4, 5, 6, 7, 8, 9: return $urandom_range(0, 33554432) - 16777216;
            default: return $urandom;
        endcase
    endfunction

    // scale factors mostly within +-4.0
    function automatic logic [31:0] rand_scale();
        case ($urandom_range(11))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'h0000_0000;
            3: return Q_ONE;
            4: return $urandom;
            default: return $urandom_range(0, 524288) - 262144;
        endcase
    endfunction

    // angles with the quadrant edges favored
    function automatic logic [15:0] rand_angle();
        case ($urandom_range(9))
            0: return 16'h4000;
            1: return 16'hC000;
            2: return 16'h3FFF;
            3: return 16'hBFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // random items; move-to comes as groups led by a first vertex, a few without one
    task automatic add_random_items(input int n);
        int   count;
        int   len;
        int   k;
        logic broken;
        t_mode m;
        count = 0;
        while (count < n) begin
            m = t_mode'($urandom_range(3));
            if (m == MODE_MOVE_TO) begin
                len = $urandom_range(1, 5);
                broken = ($urandom_range(9) == 0);
                for (k = 0; k < len; k++)
                    add_vertex(MODE_MOVE_TO, rand_coord(), rand_coord(), (k == 0) && !broken);
                count += len;
            end else begin
                add_vertex(m, rand_coord(), rand_coord(), 1'($urandom_range(1)));
                count++;
            end
        end
    endtask

    // stimulus sequence
    initial begin
        int s;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset settings: move-to with no first vertex uses the zero difference,
        // group flag set outside move-to
        @(negedge i_clk);
        add_vertex(MODE_MOVE_TO, 32'h0005_0000, 32'hFFF9_0000, 1'b0);
        add_vertex(MODE_TRANSLATE, Q_MAX, Q_MIN, 1'b1);
        add_vertex(MODE_SCALE, Q_MIN, Q_MAX, 1'b1);
        add_vertex(MODE_ROTATE, 32'h0003_8000, Q_NEG1, 1'b1);
        add_vertex(MODE_ROTATE, Q_MAX, Q_MIN, 1'b0);
        wait_drain();

        // extreme offsets and factors, quarter turn
        set_config(Q_MAX, Q_MIN, 32'h0001_0000, 32'hFFFE_0000, Q_MIN, Q_MAX, 16'h4000);
        @(negedge i_clk);
        add_vertex(MODE_TRANSLATE, Q_MAX, Q_MIN, 1'b0);
        add_vertex(MODE_TRANSLATE, Q_NEG1, 32'h0000_0001, 1'b0);
        add_vertex(MODE_MOVE_TO, 32'h0000_0000, 32'h0000_0000, 1'b1);
        add_vertex(MODE_MOVE_TO, 32'h0000_0001, 32'h0000_0000, 1'b0);
        add_vertex(MODE_MOVE_TO, Q_MIN, Q_MAX, 1'b1);
        add_vertex(MODE_SCALE, Q_MAX, Q_MIN, 1'b0);
        add_vertex(MODE_SCALE, 32'h0001_0000, 32'hFFFE_0000, 1'b0);
        add_vertex(MODE_ROTATE, 32'h0002_0000, 32'hFFFE_0000, 1'b0);
        add_vertex(MODE_ROTATE, Q_MAX, Q_MAX, 1'b0);
        wait_drain();

        // unknown register index is ignored; half turn, zero and negative factors
        write_reg(CFG_UNUSED, $urandom);
        set_config(32'h0000_0000, Q_NEG1, Q_MIN, Q_MAX, 32'h0000_0000, 32'hFFFF_0000,
                   16'h8000);
        @(negedge i_clk);
        add_vertex(MODE_SCALE, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_vertex(MODE_SCALE, 32'hFFFF_FFFB, 32'h1234_5678, 1'b0);
        add_vertex(MODE_ROTATE, Q_MAX, Q_MIN, 1'b0);
        add_vertex(MODE_ROTATE, Q_MIN, Q_MAX, 1'b0);
        add_vertex(MODE_TRANSLATE, 32'h0000_0000, Q_MIN, 1'b0);
        wait_drain();

        // three-quarter turn and the last step below a full turn
        set_config(Q_ONE, Q_ONE, 32'h0000_0000, 32'h0000_0000, Q_ONE, Q_ONE, 16'hC000);
        @(negedge i_clk);
        add_vertex(MODE_ROTATE, 32'h0001_0000, 32'h0000_0000, 1'b0);
        add_vertex(MODE_ROTATE, Q_NEG1, Q_NEG1, 1'b0);
        wait_drain();
        set_config(Q_ONE, Q_ONE, 32'h0000_0000, 32'h0000_0000, Q_ONE, Q_ONE, 16'hFFFF);
        @(negedge i_clk);
        add_vertex(MODE_ROTATE, 32'h7FFF_0000, 32'h0000_0000, 1'b0);
        add_vertex(MODE_ROTATE, 32'h0000_0000, 32'h8001_0000, 1'b0);
        wait_drain();

        // random segments, each with its own settings and idling pattern
        for (s = 0; s < N_SEGMENTS; s++) begin
            case (s)
                1: set_config(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 16'hFFFF);
                2: set_config(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 16'h0000);
                default: set_config(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                    rand_scale(), rand_scale(), rand_angle());
            endcase
            @(negedge i_clk);
            case (s % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 73;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 73;
                end
                default: begin
                    send_idle_pct = 24;
                    recv_stall_pct = 24;
                end
            endcase
            add_random_items(SEG_ITEMS);
            wait_drain();
        end

        if (n_errors == 0 && predicted_points.size() == 0)
            $display("tb_vertex_affine_transform_top: PASS");
        else
            $display("tb_vertex_affine_transform_top: FAIL");
        $finish;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("tb_vertex_affine_transform_top: FAIL");
        $finish;
    end

endmodule
